### sv/lr_pkg.sv
// shared constants and types for the line rasteriser
package lr_pkg;

	// default coordinate width of the tile
	localparam int COORD_BITS_DEF = 6;

	// depth of the segment queue between setup and stepping
	localparam int QUEUE_DEPTH = 2;

	// direction flags of one set-up segment
	typedef struct packed {
		logic x_major;
		logic x_neg;
	} lr_dir_t;

	localparam int DIR_BITS = $bits(lr_dir_t);

endpackage

### sv/line_rasterizer.sv
// top level of the tile line rasteriser
//
// takes one segment per input beat on the s_ group and emits its pixels,
// one per output beat on the m_ group, in drawing order; tlast marks the
// final pixel of each segment. endpoints are ordered so y rises (x rises on
// a horizontal segment); the far endpoint is not drawn, so a segment of
// major-axis span N gives N beats and a zero-length segment gives none.
// the setup stage registers the ordered, classified segment and pushes it
// into a two-entry queue; the stepper pops one segment at a time and walks
// it with the integer midpoint decision, one pixel per cycle while the
// receiver takes them. a segment passes the setup register, the queue and
// the stepper before its first pixel lands in the output register; the
// stepper loads the next segment from the queue only after the last pixel
// of the current one; input beats are taken one per cycle while the queue
// has room.
// reset clears the setup stage, queue and stepper; nothing is in flight.
// when the receiver stalls the output register holds its pixel, the stepper
// waits, and the queue and setup stage fill before s_tready drops.
module line_rasterizer
	import lr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W     = ((2 * COORD_BITS + 7) / 8) * 8,
	localparam int DESC_W    = 4 * COORD_BITS + DIR_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // pixel_x, pixel_y, zero pad
	output logic             m_tlast    // last_pixel
);

	// setup stage to queue
	logic              su_valid, su_ready;
	logic [DESC_W-1:0] su_data;

	// queue to stepper
	logic              q_valid, q_ready;
	logic [DESC_W-1:0] q_data;

	// ordering, span and octant classification
	lr_setup #(
		.COORD_BITS (COORD_BITS)
	) u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.desc_valid (su_valid),
		.desc_ready (su_ready),
		.desc_data  (su_data)
	);

	// decouples segment intake from pixel stepping
	lr_queue #(
		.WIDTH (DESC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (su_valid),
		.push_ready (su_ready),
		.push_data  (su_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	// midpoint walker with its own output register
	lr_stepper #(
		.COORD_BITS (COORD_BITS)
	) u_stepper (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (q_valid),
		.desc_ready (q_ready),
		.desc_data  (q_data),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

### sv/lr_setup.sv
// front end: takes a segment beat, orders endpoints and classifies the octant
module lr_setup
	import lr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int DESC_W    = 4 * COORD_BITS + DIR_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,
	output logic              desc_valid,
	input  logic              desc_ready,
	output logic [DESC_W-1:0] desc_data
);

	localparam int CB = COORD_BITS;

	logic [CB-1:0] xa, ya, xb, yb;
	logic [CB-1:0] x0, y0, x1, y1;
	logic [CB-1:0] adx, dy, major, minor;
	logic          swap;
	lr_dir_t       dir;

	logic              valid_s1;
	logic [DESC_W-1:0] desc_s1;

	assign xa = s_tdata[CB-1:0];
	assign ya = s_tdata[2*CB-1:CB];
	assign xb = s_tdata[3*CB-1:2*CB];
	assign yb = s_tdata[4*CB-1:3*CB];

	always_comb begin
		// y rises; on a horizontal segment x rises
		swap = (ya > yb) || ((ya == yb) && (xa > xb));
		x0 = swap ? xb : xa;
		y0 = swap ? yb : ya;
		x1 = swap ? xa : xb;
		y1 = swap ? ya : yb;
		dir.x_neg = (x1 < x0);
		adx = dir.x_neg ? (x0 - x1) : (x1 - x0);
		dy = y1 - y0;
		// slope +1 goes x-major, slope -1 goes y-major
		dir.x_major = (dy == '0) || (adx > dy) || ((adx == dy) && !dir.x_neg);
		major = dir.x_major ? adx : dy;
		minor = dir.x_major ? dy : adx;
	end

	assign s_tready   = !valid_s1 || desc_ready;
	assign desc_valid = valid_s1;
	assign desc_data  = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			// zero-length segments produce nothing and are dropped here
			valid_s1 <= s_tvalid && (major != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			desc_s1 <= {dir, minor, major, y0, x0};
		end
	end

endmodule

### sv/lr_queue.sv
// small register queue holding set-up segments
module lr_queue
	import lr_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/lr_stepper.sv
// back end: midpoint walk of a segment, one pixel a cycle unless stalled
module lr_stepper
	import lr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int OUT_W     = ((2 * COORD_BITS + 7) / 8) * 8,
	localparam int DESC_W    = 4 * COORD_BITS + DIR_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              desc_valid,
	output logic              desc_ready,
	input  logic [DESC_W-1:0] desc_data,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,
	output logic              m_tlast
);

	localparam int CB = COORD_BITS;
	localparam int DW = COORD_BITS + 3;

	lr_dir_t              ld_dir;
	logic [CB-1:0]        ld_x0, ld_y0, ld_major, ld_minor;

	logic                 busy_q;
	lr_dir_t              dir_q;
	logic [CB-1:0]        x_q, y_q, cnt_q;
	logic signed [DW-1:0] dec_q, inc_pos_q, inc_neg_q;
	logic                 emit;
	logic                 dec_pos;
	logic [CB-1:0]        x_step, y_step;

	logic                 out_valid_q, out_last_q;
	logic [CB-1:0]        out_x_q, out_y_q;

	assign {ld_dir, ld_minor, ld_major, ld_y0, ld_x0} = desc_data;

	assign desc_ready = !busy_q;
	assign emit       = busy_q && (!out_valid_q || m_tready);
	assign dec_pos    = (dec_q > 0);
	assign x_step     = dir_q.x_neg ? (x_q - CB'(1)) : (x_q + CB'(1));
	assign y_step     = y_q + CB'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				busy_q <= desc_valid;
			end else if (emit && (cnt_q == CB'(1))) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			dir_q     <= ld_dir;
			x_q       <= ld_x0;
			y_q       <= ld_y0;
			cnt_q     <= ld_major;
			dec_q     <= DW'({2'b00, ld_minor, 1'b0}) - DW'({3'b000, ld_major});
			inc_neg_q <= DW'({2'b00, ld_minor, 1'b0});
			inc_pos_q <= DW'({2'b00, ld_minor, 1'b0}) - DW'({2'b00, ld_major, 1'b0});
		end else if (emit) begin
			cnt_q <= cnt_q - CB'(1);
			// major axis always steps, minor axis when the decision is positive
			if (dir_q.x_major) begin
				x_q <= x_step;
				if (dec_pos) begin
					y_q <= y_step;
				end
			end else begin
				y_q <= y_step;
				if (dec_pos) begin
					x_q <= x_step;
				end
			end
			dec_q <= dec_q + (dec_pos ? inc_pos_q : inc_neg_q);
		end
		if (emit) begin
			out_x_q    <= x_q;
			out_y_q    <= y_q;
			out_last_q <= (cnt_q == CB'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_y_q, out_x_q});
	assign m_tlast  = out_last_q;

	a_busy_count : assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("stepper busy with no pixels left");

	a_last_ends : assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (cnt_q == CB'(1))) |=> (!busy_q && m_tvalid && m_tlast))
		else $error("final pixel did not end the segment");

	a_no_early_last : assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (cnt_q != CB'(1))) |=> (busy_q && !m_tlast))
		else $error("segment ended before its span");

endmodule

### tb/line_rasterizer_test.sv
// self-checking testbench for the tile line rasteriser: directed segments, then random ones
module line_rasterizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lr_pkg::*;

	localparam int CB    = COORD_BITS_DEF;
	localparam int CMAX  = (1 << CB) - 1;
	localparam int IN_W  = ((4 * CB + 7) / 8) * 8;
	localparam int OUT_W = ((2 * CB + 7) / 8) * 8;

	localparam int N_ROWS           = 22;
	localparam int N_PHASES         = 4;
	localparam int RANDOM_PER_PHASE = 25;
	localparam int MAX_REPORTS      = 10;
	localparam int SETTLE_CYCLES    = 70;   // a full span plus the pipeline

	// one segment as it sits on s_tdata, start_x in the low bits
	typedef struct packed {
		logic [CB-1:0] end_y;
		logic [CB-1:0] end_x;
		logic [CB-1:0] start_y;
		logic [CB-1:0] start_x;
	} segment_t;

	// one expected pixel beat
	typedef struct packed {
		logic [CB-1:0] y;
		logic [CB-1:0] x;
		logic          last;
	} pixel_t;

	// directed row: endpoints, and where obvious the pixel count and first pixel
	typedef struct {
		int sx, sy, ex, ey;
		bit known;
		int count;
		int first_x, first_y;
	} stim_row_t;

	// shapes for the random part
	typedef enum int {
		SHAPE_POINT,
		SHAPE_HORIZONTAL,
		SHAPE_VERTICAL,
		SHAPE_DIAGONAL,
		SHAPE_SHORT,
		SHAPE_ANY
	} shape_e;

	stim_row_t stim_table [N_ROWS] = '{
		// sx  sy  ex  ey  known count fx  fy
		'{ 0,  0,  0,  0,  1,  0,  0,  0},   // zero length at the origin
		'{63, 63, 63, 63,  1,  0,  0,  0},   // zero length at the far corner
		'{ 0,  0, 63,  0,  1, 63,  0,  0},   // full horizontal, bottom row
		'{63,  0,  0,  0,  1, 63,  0,  0},   // horizontal given backwards, x reordered
		'{ 0, 63, 63, 63,  1, 63,  0, 63},   // full horizontal, top row
		'{ 0,  0,  0, 63,  1, 63,  0,  0},   // full vertical, left column
		'{ 5, 63,  5,  0,  1, 63,  5,  0},   // vertical given downwards, y reordered
		'{63,  0, 63, 63,  1, 63, 63,  0},   // full vertical, right column
		'{ 0,  0, 63, 63,  1, 63,  0,  0},   // slope 1, x-major
		'{63,  0,  0, 63,  1, 63, 63,  0},   // slope -1, y-major
		'{ 0, 63, 63,  0,  1, 63, 63,  0},   // slope -1 given downwards
		'{63, 63,  0,  0,  1, 63,  0,  0},   // slope 1 given downwards
		'{ 0,  0, 63, 20,  0,  0,  0,  0},   // shallow, x rising
		'{63, 10,  0, 30,  0,  0,  0,  0},   // shallow, x falling
		'{10,  0, 20, 63,  0,  0,  0,  0},   // steep, x rising
		'{40,  5,  2, 60,  0,  0,  0,  0},   // steep, x falling
		'{ 7,  7,  8,  7,  1,  1,  7,  7},   // single pixel, horizontal
		'{ 7,  7,  7,  6,  1,  1,  7,  6},   // single pixel, vertical reordered
		'{ 1,  1,  2,  2,  1,  1,  1,  1},   // single pixel, slope 1
		'{ 2,  1,  1,  2,  1,  1,  2,  1},   // single pixel, slope -1
		'{42, 21, 21, 42,  1, 21, 42, 21},   // alternating bit patterns, slope -1
		'{21, 42, 42, 21,  1, 21, 42, 21}    // the same line given downwards
	};

	// sender gap and receiver stall, in percent, per phase
	int gap_plan   [N_PHASES] = '{0, 64, 0, 19};
	int stall_plan [N_PHASES] = '{0, 0, 64, 19};

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;   // start_x, start_y, end_x, end_y
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;         // pixel_x, pixel_y, zero pad
	logic             m_tlast;         // last_pixel

	pixel_t pixels_due [$];   // pixels still owed by the block, oldest first
	int     fail_count = 0;
	int     send_gap_pct = 0;
	int     recv_stall_pct = 0;

	line_rasterizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// count every failure, print only the first few
	function automatic void flag_error(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("error at %0t: %s", $realtime, msg);
	endfunction

	// midpoint walk of one segment, giving the pixels in drawing order
	function automatic void rasterise(input segment_t seg, output pixel_t pix [$]);
		int xa, ya, xb, yb, swap_tmp;
		int dx, dy, adx, xstep;
		int span_major, span_minor, decision, px, py;
		bit x_major;
		pix = {};
		xa = seg.start_x;
		ya = seg.start_y;
		xb = seg.end_x;
		yb = seg.end_y;
		// y rises; on a horizontal segment x rises
		if (ya > yb || (ya == yb && xa > xb)) begin
			swap_tmp = xa; xa = xb; xb = swap_tmp;
			swap_tmp = ya; ya = yb; yb = swap_tmp;
		end
		dx = xb - xa;
		dy = yb - ya;
		adx = (dx < 0) ? -dx : dx;
		xstep = (dx < 0) ? -1 : 1;
		// equal spans: slope 1 walks along x, slope -1 along y
		x_major = (dy == 0) || (adx > dy) || (adx == dy && dx > 0);
		span_major = x_major ? adx : dy;
		span_minor = x_major ? dy : adx;
		decision = 2 * span_minor - span_major;
		px = xa;
		py = ya;
		// far endpoint is never drawn
		for (int i = 0; i < span_major; i++) begin
			pix.insert(pix.size(),
				'{y: py[CB-1:0], x: px[CB-1:0], last: (i == span_major - 1)});
			if (x_major)
				px += xstep;
			else
				py += 1;
			if (decision > 0) begin
				if (x_major)
					py += 1;
				else
					px += xstep;
				decision += 2 * (span_minor - span_major);
			end else begin
				decision += 2 * span_minor;
			end
		end
	endfunction

	// move a coordinate by d either way, staying inside the tile
	function automatic logic [CB-1:0] nudge(input int c, input int d);
		if (c + d > CMAX)
			return CB'(c - d);
		if (c - d < 0)
			return CB'(c + d);
		return $urandom_range(1) ? CB'(c + d) : CB'(c - d);
	endfunction

	// random segment, weighted towards lines with known shape
	function automatic segment_t random_segment();
		segment_t seg;
		int pick;
		int d;
		shape_e shape;
		seg.start_x = CB'($urandom_range(CMAX));
		seg.start_y = CB'($urandom_range(CMAX));
		seg.end_x   = CB'($urandom_range(CMAX));
		seg.end_y   = CB'($urandom_range(CMAX));
		pick = $urandom_range(9);
		shape = (pick > SHAPE_ANY) ? SHAPE_ANY : shape_e'(pick);
		d = $urandom_range(CMAX / 2, 1);
		case (shape)
			SHAPE_POINT: begin
				seg.end_x = seg.start_x;
				seg.end_y = seg.start_y;
			end
			SHAPE_HORIZONTAL: seg.end_y = seg.start_y;
			SHAPE_VERTICAL:   seg.end_x = seg.start_x;
			SHAPE_DIAGONAL: begin
				seg.end_x = nudge(seg.start_x, d);
				seg.end_y = nudge(seg.start_y, d);
			end
			SHAPE_SHORT: begin
				seg.end_x = nudge(seg.start_x, $urandom_range(3));
				seg.end_y = nudge(seg.start_y, $urandom_range(3));
			end
			default: ;
		endcase
		return seg;
	endfunction

	// offer one segment, wait for its beat, then book its pixels
	task automatic send_segment(input segment_t seg, output pixel_t pix [$]);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(seg);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		rasterise(seg, pix);
		foreach (pix[i])
			pixels_due.insert(pixels_due.size(), pix[i]);
	endtask

	// hold off the sender until every booked pixel has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pixels_due.size() != 0)
			@(posedge clk);
	endtask

	// receiver: check each pixel beat against the oldest booked pixel, then
	// choose whether to stall on the next cycle
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pixels_due.size() == 0) begin
				flag_error($sformatf("pixel beat with none due: x=%0d y=%0d last=%0b",
					m_tdata[CB-1:0], m_tdata[2*CB-1:CB], m_tlast));
			end else begin
				want = pixels_due.pop_front();
				if (m_tdata[CB-1:0] !== want.x || m_tdata[2*CB-1:CB] !== want.y ||
						m_tlast !== want.last)
					flag_error($sformatf("pixel expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
						want.x, want.y, want.last,
						m_tdata[CB-1:0], m_tdata[2*CB-1:CB], m_tlast));
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// stimulus
	initial begin
		pixel_t   pix [$];
		segment_t seg;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, no idling on either side
		foreach (stim_table[r]) begin
			seg.start_x = CB'(stim_table[r].sx);
			seg.start_y = CB'(stim_table[r].sy);
			seg.end_x   = CB'(stim_table[r].ex);
			seg.end_y   = CB'(stim_table[r].ey);
			send_segment(seg, pix);
			// typed-in rows also pin down the predictor
			if (stim_table[r].known) begin
				if (pix.size() != stim_table[r].count)
					flag_error($sformatf("row %0d: %0d pixels predicted, %0d expected",
						r, pix.size(), stim_table[r].count));
				else if (pix.size() != 0 && (pix[0].x != stim_table[r].first_x ||
						pix[0].y != stim_table[r].first_y))
					flag_error($sformatf("row %0d: first pixel (%0d,%0d), expected (%0d,%0d)",
						r, pix[0].x, pix[0].y, stim_table[r].first_x, stim_table[r].first_y));
			end
		end
		drain();

		// random segments under each idling pattern, draining between phases
		for (int phase = 0; phase < N_PHASES; phase++) begin
			send_gap_pct   = gap_plan[phase];
			recv_stall_pct = stall_plan[phase];
			repeat (RANDOM_PER_PHASE) begin
				seg = random_segment();
				send_segment(seg, pix);
			end
			drain();
		end

		// let any stray beats show up before the verdict
		recv_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pixels_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
sv/lr_pkg.sv
sv/lr_setup.sv
sv/lr_queue.sv
sv/lr_stepper.sv
sv/line_rasterizer.sv
tb/line_rasterizer_test.sv
